/* rtl/core/hsvt_pkg.sv */
// Shared types and constants of the HSV color blob tracker.
// Used by every module under rtl/core but hsvt_div; depends on nothing.
`timescale 1ns / 1ps

package hsvt_pkg;

    localparam int unsigned CountW    = 25;
    localparam int unsigned SumW      = 37;
    localparam int unsigned ColW      = 12;
    localparam int unsigned WidthW    = 13;
    localparam int unsigned FovW      = 16;
    localparam int unsigned YawW      = 16;
    localparam int unsigned CfgIndexW = 8;
    localparam int unsigned CfgDataW  = 25;
    localparam int unsigned QueueD    = 4;

    localparam logic [CountW-1:0] MaxPixels = 25'd16777216;
    localparam logic [7:0]        HueWrap   = 8'd180;

    // Register indexes of the configuration port.
    localparam logic [CfgIndexW-1:0] RegHueLow    = 8'd0;
    localparam logic [CfgIndexW-1:0] RegHueHigh   = 8'd1;
    localparam logic [CfgIndexW-1:0] RegSatLow    = 8'd2;
    localparam logic [CfgIndexW-1:0] RegValLow    = 8'd3;
    localparam logic [CfgIndexW-1:0] RegMinArea   = 8'd4;
    localparam logic [CfgIndexW-1:0] RegReachArea = 8'd5;
    localparam logic [CfgIndexW-1:0] RegFov       = 8'd6;
    localparam logic [CfgIndexW-1:0] RegWidth     = 8'd7;

    typedef struct packed {
        logic [7:0]        hue_low;
        logic [7:0]        hue_high;
        logic [7:0]        sat_low;
        logic [7:0]        val_low;
        logic [CountW-1:0] min_area;
        logic [CountW-1:0] reach_area;
        logic [FovW-1:0]   field_of_view;
        logic [WidthW-1:0] frame_width;
    } cfg_t;

    // One queue entry: the classified pixel and, on a frame end that reports, the totals.
    typedef struct packed {
        logic              in_range;
        logic              report;
        logic              reached;
        logic [CountW-1:0] area;
        logic [SumW-1:0]   column_sum;
    } item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_START,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHK,
        B_WCX,
        B_MUL,
        B_SY,
        B_WY,
        B_OUT
    } back_state_t;

endpackage

/* rtl/core/hsvt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Generic; used by the front and back parts of the tracker.
`timescale 1ns / 1ps

module hsvt_div #(
    parameter int unsigned NW = 16,
    parameter int unsigned DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);

    localparam int unsigned CntW = $clog2(NW + 1);

    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic [NW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   div_reg;
    logic [DW:0]     shifted;
    logic            fits;
    logic [DW:0]     diff;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CntW'(NW);
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CntW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/hsvt_front.sv */
// Front part: accepts pixels, converts them to HSV, classifies them and
// keeps the frame totals. Depends on hsvt_pkg and hsvt_div.
`timescale 1ns / 1ps

module hsvt_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hsvt_pkg::cfg_t              cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,
    input  logic                        s_tlast,
    output logic                        push,
    output hsvt_pkg::item_t             push_item,
    input  logic                        queue_full,
    output logic                        done
);

    hsvt_pkg::front_state_t state_reg, state_next;

    logic [7:0]                   b_reg, g_reg, r_reg;
    logic [hsvt_pkg::ColW-1:0]    col_reg;
    logic                         last_reg;
    logic                         done_reg;
    logic [hsvt_pkg::CountW-1:0]  cnt_reg;
    logic [hsvt_pkg::SumW-1:0]    sum_reg;

    logic [7:0]  mx, mn, d;
    logic [15:0] n;
    logic        div_start;
    logic        sat_busy, hue_busy;
    logic [15:0] sat_q;
    logic [16:0] hue_q;
    logic [7:0]  sat, hue;
    logic        hit, take;
    logic [hsvt_pkg::CountW-1:0] cnt_new;
    logic [hsvt_pkg::SumW-1:0]   sum_new;
    logic        report, reached;
    logic        accept;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        mx = r_reg;
        mn = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        d = mx - mn;
        if (mx == r_reg)
            n = (g_reg >= b_reg) ? 16'(30 * (g_reg - b_reg))
                                 : 16'(180 * d - 30 * (b_reg - g_reg));
        else if (mx == g_reg)
            n = (b_reg >= r_reg) ? 16'(60 * d + 30 * (b_reg - r_reg))
                                 : 16'(60 * d - 30 * (r_reg - b_reg));
        else
            n = (r_reg >= g_reg) ? 16'(120 * d + 30 * (r_reg - g_reg))
                                 : 16'(120 * d - 30 * (g_reg - r_reg));
    end

    hsvt_div #(.NW(16), .DW(8)) u_sat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (16'(255 * d) + {9'd0, mx[7:1]}),
        .divisor  (mx),
        .busy     (sat_busy),
        .quotient (sat_q)
    );

    hsvt_div #(.NW(17), .DW(9)) u_hue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({n, 1'b0} + {9'd0, d}),
        .divisor  ({d, 1'b0}),
        .busy     (hue_busy),
        .quotient (hue_q)
    );

    always_comb
    begin
        sat = (mx == 8'd0) ? 8'd0 : sat_q[7:0];
        if (d == 8'd0)
            hue = 8'd0;
        else if (hue_q[7:0] >= hsvt_pkg::HueWrap)
            hue = hue_q[7:0] - hsvt_pkg::HueWrap;
        else
            hue = hue_q[7:0];
        hit = (hue >= cfg.hue_low) && (hue <= cfg.hue_high) &&
              (sat >= cfg.sat_low) && (mx >= cfg.val_low);
        take    = hit && (cnt_reg < hsvt_pkg::MaxPixels);
        cnt_new = take ? cnt_reg + 1'b1 : cnt_reg;
        sum_new = take ? sum_reg + {25'd0, col_reg} : sum_reg;
        report  = last_reg && (cnt_new > cfg.min_area);
        reached = report && (cnt_new > cfg.reach_area);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsvt_pkg::F_IDLE:
                if (accept && !done_reg) state_next = hsvt_pkg::F_START;
            hsvt_pkg::F_START:
                state_next = hsvt_pkg::F_DIV;
            hsvt_pkg::F_DIV:
                if (!sat_busy && !hue_busy) state_next = hsvt_pkg::F_PUSH;
            hsvt_pkg::F_PUSH:
                if (!queue_full) state_next = hsvt_pkg::F_IDLE;
            default:
                state_next = hsvt_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == hsvt_pkg::F_IDLE);
        div_start = (state_reg == hsvt_pkg::F_START);
        push      = (state_reg == hsvt_pkg::F_PUSH) && !queue_full;
        push_item.in_range   = hit;
        push_item.report     = report;
        push_item.reached    = reached;
        push_item.area       = report ? cnt_new : '0;
        push_item.column_sum = report ? sum_new : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsvt_pkg::F_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                if (reached) done_reg <= 1'b1;
                cnt_reg <= last_reg ? '0 : cnt_new;
                sum_reg <= last_reg ? '0 : sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg    <= s_tdata[7:0];
            g_reg    <= s_tdata[15:8];
            r_reg    <= s_tdata[23:16];
            col_reg  <= s_tdata[35:24];
            last_reg <= s_tlast;
        end
    end

    assign done = done_reg;

    // Once latched, the tracker stays latched until reset.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg) else $error("done latch cleared");

    // A latched tracker starts no further pixel.
    a_no_work_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && state_reg == hsvt_pkg::F_IDLE) |=> state_reg == hsvt_pkg::F_IDLE)
        else $error("pixel processed after latch");

endmodule

/* rtl/core/hsvt_queue.sv */
// Short queue of classified pixels between front and back parts.
// Depends on hsvt_pkg.
`timescale 1ns / 1ps

module hsvt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsvt_pkg::item_t push_item,
    input  logic            pop,
    output hsvt_pkg::item_t pop_item,
    output logic            full,
    output logic            empty
);

    localparam int unsigned PtrW = $clog2(hsvt_pkg::QueueD);

    hsvt_pkg::item_t   mem_reg [hsvt_pkg::QueueD];
    logic [PtrW-1:0]   wr_reg, rd_reg;
    logic [PtrW:0]     cnt_reg;

    assign full     = (cnt_reg == (PtrW+1)'(hsvt_pkg::QueueD));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(hsvt_pkg::QueueD)) else $error("queue overfilled");

endmodule

/* rtl/core/hsvt_back.sv */
// Back part: turns frame totals into a yaw error and drives the result beat.
// Depends on hsvt_pkg and hsvt_div.
`timescale 1ns / 1ps

module hsvt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hsvt_pkg::cfg_t  cfg,
    input  logic            empty,
    input  hsvt_pkg::item_t pop_item,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [47:0]     m_tdata
);

    hsvt_pkg::back_state_t state_reg, state_next;

    hsvt_pkg::item_t             item_reg;
    logic [hsvt_pkg::ColW-1:0]   cx_reg;
    logic [29:0]                 mag_reg;
    logic                        neg_reg;
    logic                        out_valid_reg;
    logic [47:0]                 out_reg;

    logic [hsvt_pkg::WidthW-1:0] w_eff;
    logic [14:0]                 diff;
    logic [13:0]                 diff_mag;
    logic                        div_start, div_busy;
    logic [36:0]                 div_num, div_q;
    logic [24:0]                 div_den;
    logic signed [hsvt_pkg::YawW-1:0] yaw;
    logic                        load;

    assign w_eff    = (cfg.frame_width == '0) ? 13'd1 : cfg.frame_width;
    assign diff     = {2'b00, w_eff} - {2'b00, cx_reg, 1'b0};
    assign diff_mag = diff[14] ? 14'(-diff) : diff[13:0];

    always_comb
    begin
        if (state_reg == hsvt_pkg::B_CHK)
        begin
            div_num = item_reg.column_sum;
            div_den = item_reg.area;
        end
        else
        begin
            div_num = 37'(mag_reg) + 37'(w_eff);
            div_den = 25'({w_eff, 1'b0});
        end
    end

    hsvt_div #(.NW(37), .DW(25)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        if (!neg_reg)
            yaw = (div_q > 37'd32767) ? 16'sd32767 : $signed(div_q[15:0]);
        else
            yaw = (div_q > 37'd32768) ? -16'sd32768 : $signed(16'(-div_q[15:0]));
        if (!item_reg.report) yaw = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hsvt_pkg::B_IDLE:
                if (!empty) state_next = hsvt_pkg::B_CHK;
            hsvt_pkg::B_CHK:
                state_next = item_reg.report ? hsvt_pkg::B_WCX : hsvt_pkg::B_OUT;
            hsvt_pkg::B_WCX:
                if (!div_busy) state_next = hsvt_pkg::B_MUL;
            hsvt_pkg::B_MUL:
                state_next = hsvt_pkg::B_SY;
            hsvt_pkg::B_SY:
                state_next = hsvt_pkg::B_WY;
            hsvt_pkg::B_WY:
                if (!div_busy) state_next = hsvt_pkg::B_OUT;
            hsvt_pkg::B_OUT:
                if (!out_valid_reg || m_tready) state_next = hsvt_pkg::B_IDLE;
            default:
                state_next = hsvt_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == hsvt_pkg::B_IDLE) && !empty;
        div_start = ((state_reg == hsvt_pkg::B_CHK) && item_reg.report) ||
                    (state_reg == hsvt_pkg::B_SY);
        load      = (state_reg == hsvt_pkg::B_OUT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsvt_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) item_reg <= pop_item;
        if (state_reg == hsvt_pkg::B_WCX && !div_busy) cx_reg <= div_q[11:0];
        if (state_reg == hsvt_pkg::B_MUL)
        begin
            mag_reg <= 30'(diff_mag) * 30'(cfg.field_of_view);
            neg_reg <= diff[14];
        end
        if (load)
            out_reg <= {4'd0, item_reg.reached, item_reg.area, yaw,
                        item_reg.report, item_reg.in_range};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_reached_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg[43] && !out_reg[1])) else $error("reach without report");

endmodule

/* rtl/core/hsv_color_blob_tracker.sv */
// HSV color blob tracker, top level: configuration registers, front part,
// queue and back part. Depends on hsvt_pkg, hsvt_front, hsvt_queue, hsvt_back.
// In the front each pixel goes through two 16/17-step HSV dividers;
// a frame end adds two 37-step divisions and one multiply in the back.
// The front takes no new pixel until the last one has gone into the queue.
// Reset (rst_n, async, active low) loads defaults, clears totals, queue, latch.
`timescale 1ns / 1ps

module hsv_color_blob_tracker (
    input  logic        clk,
    input  logic        rst_n,
    // Pixel beats: tdata = blue[7:0], green[15:8], red[23:16], column[35:24],
    // zero fill [39:36]; tlast = frame_end.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    // Result beats: tdata = in_range[0], report_valid[1], heading_err[17:2],
    // area[42:18], target_reached[43], zero fill [47:44].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // Configuration writes: cfg_index selects the register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [hsvt_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [hsvt_pkg::CfgDataW-1:0]  cfg_data
);

    hsvt_pkg::cfg_t  cfg_reg;
    hsvt_pkg::item_t push_item, pop_item;
    logic            push, pop, queue_full, queue_empty, done;

    // Writes are always taken; an index beyond the register list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low       <= 8'd35;
            cfg_reg.hue_high      <= 8'd85;
            cfg_reg.sat_low       <= 8'd100;
            cfg_reg.val_low       <= 8'd100;
            cfg_reg.min_area      <= 25'd500;
            cfg_reg.reach_area    <= 25'd10000;
            cfg_reg.field_of_view <= 16'd34308;
            cfg_reg.frame_width   <= 13'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hsvt_pkg::RegHueLow:    cfg_reg.hue_low       <= cfg_data[7:0];
                hsvt_pkg::RegHueHigh:   cfg_reg.hue_high      <= cfg_data[7:0];
                hsvt_pkg::RegSatLow:    cfg_reg.sat_low       <= cfg_data[7:0];
                hsvt_pkg::RegValLow:    cfg_reg.val_low       <= cfg_data[7:0];
                hsvt_pkg::RegMinArea:   cfg_reg.min_area      <= cfg_data;
                hsvt_pkg::RegReachArea: cfg_reg.reach_area    <= cfg_data;
                hsvt_pkg::RegFov:       cfg_reg.field_of_view <= cfg_data[15:0];
                hsvt_pkg::RegWidth:     cfg_reg.frame_width   <= cfg_data[12:0];
                default:                cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // The front classifies each pixel and keeps the running count and
    // column sum; on a frame end it also decides report and latch.
    hsvt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full),
        .done       (done)
    );

    // The queue lets the front keep taking pixels while the back works
    // out a frame's yaw error.
    hsvt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    hsvt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .empty    (queue_empty),
        .pop_item (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A latched tracker produces no new queue entries.
    a_no_push_latched: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !push) else $error("queue entry after latch");

    // Only a reporting entry can carry the reached flag.
    a_push_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.reached) |-> push_item.report)
        else $error("reached without report");

    // Queue never written while full or read while empty.
    a_queue_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && queue_full) && !(pop && queue_empty))
        else $error("queue misuse");

endmodule

/* test/tb_top.sv */
// Self-checking bench for hsv_color_blob_tracker: pixel beats from a queue,
// an HSV/centroid predictor and a result checker. Depends on hsvt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    // One pixel beat as the sender offers it.
    typedef struct {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] column;
        logic        frame_end;
    } pixel_t;

    // One expected result beat.
    typedef struct {
        logic        in_range;
        logic        report;
        logic [15:0] yaw;
        logic [24:0] area;
        logic        reached;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [hsvt_pkg::CfgIndexW-1:0] cfg_index;
    logic [hsvt_pkg::CfgDataW-1:0]  cfg_data;

    hsv_color_blob_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pixels waiting to be offered, and results the tracker still owes us.
    pixel_t   pixel_q[$];
    verdict_t verdict_q[$];
    pixel_t   offered;
    int       mismatches;
    int       results_seen;

    // Shadow copy of the configuration registers.
    int unsigned sh_hue_low, sh_hue_high, sh_sat_low, sh_val_low;
    int unsigned sh_min_area, sh_reach_area, sh_fov, sh_width;

    // Shadow copy of the frame totals and the target latch.
    int unsigned trk_hits;
    longint      trk_colsum;
    bit          trk_latched;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // 8-bit HSV with hue in half degrees, all rounding done on exact ratios.
    function automatic void rgb_to_hsv(input int unsigned b, input int unsigned g,
                                       input int unsigned r, output int unsigned h,
                                       output int unsigned s, output int unsigned v);
        int unsigned mx;
        int unsigned mn;
        int unsigned d;
        int unsigned n;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        v = mx;
        s = (mx == 0) ? 0 : (255 * d + mx / 2) / mx;
        h = 0;
        if (d != 0)
        begin
            // The hue sector follows whichever component is the largest,
            // with red winning ties, then green.
            if (mx == r)
                n = (g >= b) ? 30 * (g - b) : 180 * d - 30 * (b - g);
            else if (mx == g)
                n = (b >= r) ? 60 * d + 30 * (b - r) : 60 * d - 30 * (r - b);
            else
                n = (r >= g) ? 120 * d + 30 * (r - g) : 120 * d - 30 * (g - r);
            h = (2 * n + d) / (2 * d);
            if (h >= 180) h -= 180;
        end
    endfunction

    // Yaw error in Q1.15, rounded half away from zero, saturated to 16 bits.
    function automatic logic [15:0] steering_yaw(input longint cx);
        longint w;
        longint num;
        longint mag;
        longint q;
        w = (sh_width == 0) ? 1 : sh_width;
        num = (w - 2 * cx) * longint'(sh_fov);
        mag = (num < 0) ? -num : num;
        q = (2 * mag + 2 * w) / (4 * w);
        if (num < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Classifies one accepted pixel, updates the frame totals and queues the
    // result it causes. A latched tracker answers nothing at all.
    function automatic void track_pixel(input pixel_t px);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        verdict_t    vd;
        if (trk_latched) return;
        rgb_to_hsv(32'(px.blue), 32'(px.green), 32'(px.red), h, s, v);
        vd = '{default: '0};
        vd.in_range = (h >= sh_hue_low) && (h <= sh_hue_high) &&
                      (s >= sh_sat_low) && (v >= sh_val_low);
        if (vd.in_range && trk_hits < 16777216)
        begin
            trk_hits++;
            trk_colsum += longint'(px.column);
        end
        if (px.frame_end)
        begin
            if (trk_hits > sh_min_area)
            begin
                vd.report  = 1'b1;
                vd.yaw     = steering_yaw(trk_colsum / trk_hits);
                vd.area    = 25'(trk_hits);
                vd.reached = trk_hits > sh_reach_area;
                if (vd.reached) trk_latched = 1'b1;
            end
            trk_hits   = 0;
            trk_colsum = 0;
        end
        verdict_q.push_back(vd);
    endfunction

    // Sender: bursts of random length, random gaps in between. It keeps
    // offering during the receiver's long hold-off so the tracker backs up.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                track_pixel(offered);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    offered = pixel_q.pop_front();
                    s_tdata  <= {4'b0, offered.column, offered.red, offered.green,
                                 offered.blue};
                    s_tlast  <= offered.frame_end;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        // Some bursts run back to back, so gaps hit every
                        // phase of the divider and some stretches have none.
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                  : $urandom_range(1, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, alternating between a choppy mode
    // and a mode that is always ready. After 40 results it holds off once
    // for a long stretch to fill the tracker's internal queue.
    int  mode_left;
    bit  choppy;
    int  hold_left;
    bit  hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            mode_left <= 0;
            choppy    <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat: tdata=%h", m_tdata);
                end
                else
                begin
                    verdict_t vd;
                    vd = verdict_q.pop_front();
                    if (m_tdata[0] !== vd.in_range || m_tdata[1] !== vd.report ||
                        m_tdata[17:2] !== vd.yaw || m_tdata[42:18] !== vd.area ||
                        m_tdata[43] !== vd.reached || m_tdata[47:44] !== 4'b0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch: expected in_range=%b report=%b yaw=%0d %s%0d %s%b",
                                     vd.in_range, vd.report, $signed(vd.yaw), "area=",
                                     vd.area, "reached=", vd.reached);
                            $display("          got in_range=%b report=%b yaw=%0d %s%0d %s%b",
                                     m_tdata[0], m_tdata[1], $signed(m_tdata[17:2]),
                                     "area=", m_tdata[42:18], "reached=", m_tdata[43]);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!hold_done && results_seen >= 40)
            begin
                hold_done <= 1'b1;
                hold_left <= 600;
                m_tready  <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left <= $urandom_range(16, 96);
                    choppy    <= $urandom_range(0, 1);
                end
                else
                    mode_left <= mode_left - 1;
                m_tready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
            end
        end
    end

    // Writes one register and mirrors it into the shadow copy on the beat.
    task automatic write_reg(input logic [hsvt_pkg::CfgIndexW-1:0] idx,
                             input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[hsvt_pkg::CfgDataW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hsvt_pkg::RegHueLow:    sh_hue_low    = value & 8'hFF;
            hsvt_pkg::RegHueHigh:   sh_hue_high   = value & 8'hFF;
            hsvt_pkg::RegSatLow:    sh_sat_low    = value & 8'hFF;
            hsvt_pkg::RegValLow:    sh_val_low    = value & 8'hFF;
            hsvt_pkg::RegMinArea:   sh_min_area   = value & 25'h1FFFFFF;
            hsvt_pkg::RegReachArea: sh_reach_area = value & 25'h1FFFFFF;
            hsvt_pkg::RegFov:       sh_fov        = value & 16'hFFFF;
            hsvt_pkg::RegWidth:     sh_width      = value & 13'h1FFF;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input int unsigned hl, input int unsigned hh,
                             input int unsigned sl, input int unsigned vl,
                             input int unsigned mina, input int unsigned reach,
                             input int unsigned fov, input int unsigned w);
        write_reg(hsvt_pkg::RegHueLow, hl);
        write_reg(hsvt_pkg::RegHueHigh, hh);
        write_reg(hsvt_pkg::RegSatLow, sl);
        write_reg(hsvt_pkg::RegValLow, vl);
        write_reg(hsvt_pkg::RegMinArea, mina);
        write_reg(hsvt_pkg::RegReachArea, reach);
        write_reg(hsvt_pkg::RegFov, fov);
        write_reg(hsvt_pkg::RegWidth, w);
    endtask

    // Waits until every pixel is sent and answered, then lets a frame end
    // that may still be in the back part run out before touching registers.
    task automatic drain();
        while (pixel_q.size() > 0 || s_tvalid || verdict_q.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic void add_pixel(input int unsigned b, input int unsigned g,
                                      input int unsigned r, input int unsigned col,
                                      input bit last);
        pixel_t px;
        px.blue      = 8'(b);
        px.green     = 8'(g);
        px.red       = 8'(r);
        px.column    = 12'(col);
        px.frame_end = last;
        pixel_q.push_back(px);
    endfunction

    // A frame of random pixels. Columns mostly stay inside the frame width,
    // now and then anywhere in the 12-bit range.
    function automatic void add_frame(input int len);
        int unsigned wmax;
        int unsigned col;
        wmax = (sh_width == 0) ? 0 : ((sh_width > 4096) ? 4095 : sh_width - 1);
        for (int i = 0; i < len; i++)
        begin
            col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, wmax);
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), col, i == len - 1);
        end
    endfunction

    initial
    begin
        int unsigned w;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        results_seen = 0;
        sh_hue_low = 35; sh_hue_high = 85; sh_sat_low = 100; sh_val_low = 100;
        sh_min_area = 500; sh_reach_area = 10000; sh_fov = 34308; sh_width = 640;
        trk_hits = 0; trk_colsum = 0; trk_latched = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: black, white, the primaries, a hue that rounds up
        // to 180 and wraps to zero, and the column extremes. Too few hits to
        // report against the default minimum area.
        add_pixel(0, 0, 0, 0, 0);
        add_pixel(255, 255, 255, 4095, 0);
        add_pixel(0, 0, 255, 1, 0);
        add_pixel(0, 255, 0, 2048, 0);
        add_pixel(255, 0, 0, 639, 0);
        add_pixel(1, 0, 255, 100, 0);
        add_pixel(0, 200, 0, 3000, 0);
        add_pixel(128, 255, 127, 7, 1);
        drain();

        // Everything in range, reports on any hit; width of one drives the
        // yaw into saturation, columns outside the frame are taken as given.
        write_all(0, 179, 0, 0, 0, 16777216, 65535, 1);
        write_reg(8'd200, 25'h1FFFFFF);
        add_pixel(255, 255, 255, 4095, 1);
        add_pixel(0, 0, 0, 0, 1);
        add_pixel(10, 20, 30, 0, 0);
        add_pixel(90, 80, 70, 0, 1);
        drain();
        // A zero width counts as one; then the widest frame.
        write_reg(hsvt_pkg::RegWidth, 0);
        add_pixel(0, 255, 255, 3, 1);
        drain();
        write_all(179, 0, 255, 255, 16777216, 0, 0, 4096);
        add_pixel(0, 0, 255, 4095, 1);
        add_pixel(255, 255, 255, 0, 1);
        drain();
        write_all(0, 179, 0, 0, 1, 16777216, 34308, 4096);
        add_pixel(40, 250, 30, 4095, 0);
        add_pixel(40, 250, 30, 4095, 0);
        add_pixel(40, 250, 30, 4095, 1);
        drain();

        // Random settings per phase, short frames so reports come often.
        for (int ph = 0; ph < 6; ph++)
        begin
            case ($urandom_range(0, 3))
                0: w = 1;
                1: w = 4096;
                default: w = $urandom_range(2, 4095);
            endcase
            write_all($urandom_range(0, 60), $urandom_range(100, 179),
                      $urandom_range(0, 120), $urandom_range(0, 120),
                      $urandom_range(0, 4), 16777216, $urandom_range(0, 65535), w);
            for (int n = 0; n < 65; n += 0)
            begin
                int len;
                len = $urandom_range(1, 12);
                add_frame(len);
                n += len;
            end
            drain();
        end

        // Reach the target: the frame reports, latches, and nothing after
        // it is answered.
        write_all(0, 179, 0, 0, 0, 0, 20000, 320);
        add_pixel(255, 255, 255, 10, 0);
        add_pixel(0, 255, 0, 20, 1);
        for (int i = 0; i < 6; i++)
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 4095), i == 5);
        drain();
        repeat (200) @(posedge clk);

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
